// ===== sv/rd64_pkg.sv =====
// ----------------------------------------------------------------------------
// rd64_pkg
// Shared types and constants of the 64-bit reciprocal divider.
// ----------------------------------------------------------------------------
package rd64_pkg;

  typedef logic [63:0]  word_t;
  typedef logic [127:0] dword_t;

  // Numerator and base of the reciprocal seed table.
  localparam int unsigned TBL_NUM  = 32'h0007_fd00;
  localparam int unsigned TBL_BASE = 32'h0000_0100;

  // 2^60, the fixed-point one of the second refinement step.
  localparam word_t ONE60 = 64'h1000_0000_0000_0000;

  // Everything that rides alongside the reciprocal computation.
  typedef struct packed {
    logic        dz;
    word_t       d;
    word_t       uh;
    word_t       ul;
    logic [40:0] d40;
    word_t       d63;
  } carry_t;

endpackage

// ===== sv/reciprocal_divide_64_top.sv =====
// ----------------------------------------------------------------------------
// reciprocal_divide_64_top
// Pipelined 64-bit unsigned divider using a normalized reciprocal.
// ----------------------------------------------------------------------------
// The divider accepts one dividend/divisor word per clock unless the output
// stalls. The result word with the quotient floor(dividend / divisor) shows
// on the output once its input word has passed all stages. In steady state,
// with out_ready high, one result word leaves per clock. The pipeline has 29
// register stages. One captures the input word, two find the leading-zero
// count of the divisor, and one normalizes divisor and dividend. The rest
// form the reciprocal and then the 2-by-1 quotient with two corrections. The
// reciprocal is built from a seed table, three refinement steps and a final
// correction. Every stage holds at most one 32x32 multiplier per partial
// product or one wide add. The exceptions are the two narrow 22x41 products
// of the first two refinement steps. The 64x64 products are split over two
// stages. The whole pipeline advances together: when the output word is held
// because out_ready is low, every stage holds and in_ready drops, so nothing
// is lost or repeated. A zero divisor returns quotient 0 with divide_by_zero
// set.
module reciprocal_divide_64_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rd64_pkg::word_t dividend,
  input  rd64_pkg::word_t divisor,
  output logic            out_valid,
  input  logic            out_ready,
  output rd64_pkg::word_t quotient,
  output logic            divide_by_zero
);
  import rd64_pkg::*;

  localparam int NLVL = 29;
  localparam int NCY  = 24;

  logic            en;
  logic [NLVL-1:0] vld;

  // Reciprocal seed table: 0x7fd00 / (256 + index).
  logic [10:0] lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_lut
    localparam logic [10:0] ENT = 11'(TBL_NUM / (TBL_BASE + g));
    assign lut[g] = ENT;
  end

  // Stage registers, numbered by pipeline level.
  word_t       a0, b0, a1, b1, a2, b2;
  logic        dz0, dz1, dz2, dz3;
  logic [7:0]  nz1;
  logic [2:0]  lz1 [8];
  logic [5:0]  sh2;
  word_t       d3, uh3, ul3;
  carry_t      cy [NCY];
  logic [10:0] v0_4, v0_5, v0_6;
  logic [21:0] sq5;
  logic [62:0] m1_6, p8;
  logic [21:0] v1_7, v1_8, v1_9, v1_10;
  word_t       t9;
  logic [53:0] wl10;
  logic [31:0] wh10;
  logic [35:0] v2_11, v2_12, v2_13, v2_14, v2_15;
  word_t       pp0_12, mask12, e13;
  logic [31:0] pp1_12, pp2_12;
  dword_t      pr15, pr18, pr22;
  word_t       v3_16, v3_17, v3_18, v3_19, phd19, v20;
  logic        c19, c23;
  word_t       sl23, qhu23, qh24, sl24, qh25, sl25, pq0;
  logic [31:0] pq1, pq2;
  word_t       r26, qh26, sl26, q27, r27;

  // Combinational helpers.
  logic [7:0]   nz_c;
  logic [2:0]   lz_c [8];
  logic [5:0]   sh_c;
  logic         sh_found;
  dword_t       ushift;
  logic [23:0]  v1_w;
  word_t        w_c;
  logic [64:0]  s19, s23;

  assign en        = !vld[NLVL-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NLVL-1];

  // Valid bits travel with the data and stall with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NLVL-2:0], in_valid};
    end
  end

  // Per-byte nonzero flags and leading-zero counts of the divisor.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      nz_c[k] = |b0[8*k +: 8];
      lz_c[k] = '0;
      for (int j = 0; j < 8; j++) begin
        if (b0[8*k + j]) begin
          lz_c[k] = 3'(7 - j);
        end
      end
    end
  end

  // The highest nonzero byte sets the normalizing shift.
  always_comb begin
    sh_c     = '0;
    sh_found = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      if (!sh_found && nz1[k]) begin
        sh_c     = 6'((7 - k) * 8) + {3'b0, lz1[k]};
        sh_found = 1'b1;
      end
    end
  end

  assign ushift = {64'b0, a2} << sh2;
  assign v1_w   = 24'({v0_6, 11'b0}) - 24'(m1_6[62:40]) - 24'd1;
  assign w_c    = 64'(wl10) + {wh10, 32'b0};
  assign s19    = {1'b0, pr18[63:0]} + {1'b0, cy[14].d};
  assign s23    = {1'b0, pr22[63:0]} + {1'b0, cy[18].ul};

  always_ff @(posedge clk) begin
    if (en) begin
      // Input and normalization.
      a0  <= dividend;
      b0  <= divisor;
      dz0 <= (divisor == '0);
      a1  <= a0;
      b1  <= b0;
      dz1 <= dz0;
      nz1 <= nz_c;
      lz1 <= lz_c;
      a2  <= a1;
      b2  <= b1;
      dz2 <= dz1;
      sh2 <= sh_c;
      d3  <= b2 << sh2;
      uh3 <= ushift[127:64];
      ul3 <= ushift[63:0];
      dz3 <= dz2;

      cy[0] <= '{dz: dz3, d: d3, uh: uh3, ul: ul3,
                 d40: {1'b0, d3[63:24]} + 41'd1,
                 d63: {1'b0, d3[63:1]} + {63'b0, d3[0]}};
      for (int j = 1; j < NCY; j++) begin
        cy[j] <= cy[j-1];
      end

      // Seed and first refinement.
      v0_4 <= lut[d3[62:55]];
      sq5  <= {11'b0, v0_4} * {11'b0, v0_4};
      v0_5 <= v0_4;
      m1_6 <= 63'(sq5) * 63'(cy[1].d40);
      v0_6 <= v0_5;
      v1_7 <= v1_w[21:0];

      // Second refinement.
      p8    <= 63'(v1_7) * 63'(cy[3].d40);
      v1_8  <= v1_7;
      t9    <= ONE60 - 64'(p8);
      v1_9  <= v1_8;
      wl10  <= 54'(v1_9) * 54'(t9[31:0]);
      wh10  <= 32'(v1_9) * t9[63:32];
      v1_10 <= v1_9;
      v2_11 <= 36'({v1_10, 13'b0}) + 36'(w_c[63:47]);

      // Third refinement: error term, then v2 * e through the multiplier.
      pp0_12 <= 64'(v2_11[31:0]) * 64'(cy[7].d63[31:0]);
      pp1_12 <= v2_11[31:0] * cy[7].d63[63:32];
      pp2_12 <= 32'(v2_11[35:32]) * cy[7].d63[31:0];
      mask12 <= 64'(v2_11[35:1]) & {64{cy[7].d[0]}};
      v2_12  <= v2_11;
      e13    <= mask12 - pp0_12 - {pp1_12 + pp2_12, 32'b0};
      v2_13  <= v2_12;
      v2_14  <= v2_13;
      v2_15  <= v2_14;
      v3_16  <= {v2_15[32:0], 31'b0} + {1'b0, pr15[127:65]};

      // Final reciprocal correction.
      v3_17 <= v3_16;
      v3_18 <= v3_17;
      c19   <= s19[64];
      phd19 <= pr18[127:64] + cy[14].d;
      v3_19 <= v3_18;
      v20   <= v3_19 - phd19 - {63'b0, c19};

      // Quotient estimate.
      c23   <= s23[64];
      sl23  <= s23[63:0];
      qhu23 <= pr22[127:64] + cy[18].uh + 64'd1;
      qh24  <= qhu23 + {63'b0, c23};
      sl24  <= sl23;
      pq0   <= 64'(qh24[31:0]) * 64'(cy[20].d[31:0]);
      pq1   <= qh24[31:0] * cy[20].d[63:32];
      pq2   <= qh24[63:32] * cy[20].d[31:0];
      qh25  <= qh24;
      sl25  <= sl24;
      r26   <= cy[21].ul - pq0 - {pq1 + pq2, 32'b0};
      qh26  <= qh25;
      sl26  <= sl25;

      // Two corrections of the estimate.
      if (r26 > sl26) begin
        q27 <= qh26 - 64'd1;
        r27 <= r26 + cy[22].d;
      end else begin
        q27 <= qh26;
        r27 <= r26;
      end
      quotient       <= cy[23].dz ? '0 : q27 + 64'(r27 >= cy[23].d);
      divide_by_zero <= cy[23].dz;
    end
  end

  rd64_mul u_mul_ve (
    .clk (clk),
    .en  (en),
    .a   (64'(v2_13)),
    .b   (e13),
    .p   (pr15)
  );

  rd64_mul u_mul_vd (
    .clk (clk),
    .en  (en),
    .a   (v3_16),
    .b   (cy[12].d),
    .p   (pr18)
  );

  rd64_mul u_mul_vu (
    .clk (clk),
    .en  (en),
    .a   (v20),
    .b   (cy[16].uh),
    .p   (pr22)
  );

endmodule

// ===== sv/rd64_mul.sv =====
// ----------------------------------------------------------------------------
// rd64_mul
// Two-stage 64x64 to 128-bit unsigned multiplier built from 32x32 products.
// ----------------------------------------------------------------------------
module rd64_mul (
  input  logic            clk,
  input  logic            en,
  input  rd64_pkg::word_t a,
  input  rd64_pkg::word_t b,
  output rd64_pkg::dword_t p
);
  import rd64_pkg::*;

  word_t ll, lh, hl, hh;

  // First stage forms the four partial products, second stage adds them.
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(a[31:0])  * 64'(b[31:0]);
      lh <= 64'(a[31:0])  * 64'(b[63:32]);
      hl <= 64'(a[63:32]) * 64'(b[31:0]);
      hh <= 64'(a[63:32]) * 64'(b[63:32]);
      p  <= {hh, ll} + {32'b0, lh, 32'b0} + {32'b0, hl, 32'b0};
    end
  end

endmodule

// ===== sv/rd64_checker.sv =====
// ----------------------------------------------------------------------------
// rd64_checker
// Port-level checks of the reciprocal divider, bound to the top level.
// ----------------------------------------------------------------------------
module rd64_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input rd64_pkg::word_t quotient,
  input logic            divide_by_zero
);
  import rd64_pkg::*;

  // A held result word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(divide_by_zero))
    else $error("result word changed while stalled");

  // A zero divisor always gives a zero quotient.
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> quotient == '0)
    else $error("nonzero quotient with divide by zero");

  // The pipeline accepts a word exactly when its output can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the pipeline stall");

  // Reset empties the pipeline.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind reciprocal_divide_64_top rd64_checker u_rd64_checker (.*);
